// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the I2C bit-level master.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/i2cbm_pkg.sv =====
// Package for the I2C bit-level master: phase and command codes, payload structs.
// Depends on nothing; used by the engine, the top level, the checker and the testbench.
package i2cbm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam logic [15:0] TICKS_RESET = 16'd5;

    localparam logic [2:0] FUNC_START   = 3'd0;
    localparam logic [2:0] FUNC_STOP    = 3'd1;
    localparam logic [2:0] FUNC_WRITE   = 3'd2;
    localparam logic [2:0] FUNC_READ    = 3'd3;
    localparam logic [2:0] FUNC_RELEASE = 3'd4;

    typedef enum logic [3:0] {
        P_IDLE    = 4'd0,
        P_START_A = 4'd1,
        P_START_B = 4'd2,
        P_START_C = 4'd3,
        P_STOP_A  = 4'd4,
        P_STOP_B  = 4'd5,
        P_STOP_C  = 4'd6,
        P_TX_DATA = 4'd7,
        P_TX_HIGH = 4'd8,
        P_TX_LOW  = 4'd9,
        P_TX_ACK  = 4'd10,
        P_RX_HIGH = 4'd11,
        P_RX_LOW  = 4'd12,
        P_RX_ACKD = 4'd13,
        P_RX_ACKH = 4'd14
    } t_phase;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       nack_to_send;
        logic       sda_in;
    } t_cmd;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } t_res;

endpackage

// ===== hw/rtl/i2cbm_cmd_if.sv =====
// Tick channel into the I2C bit-level master: handshake and command payload.
// Depends on nothing.
interface i2cbm_cmd_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       nack_to_send;
    logic       sda_in;

    modport source (output valid, cmd_valid, func, tx_byte, nack_to_send, sda_in,
                    input ready);
    modport sink (input valid, cmd_valid, func, tx_byte, nack_to_send, sda_in,
                  output ready);
endinterface

// ===== hw/rtl/i2cbm_res_if.sv =====
// Result channel out of the I2C bit-level master: handshake and line/status payload.
// Depends on nothing.
interface i2cbm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;

    modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    rx_byte, ack_seen, input ready);
    modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_seen, output ready);
endinterface

// ===== hw/rtl/i2cbm_engine.sv =====
// Bus phase engine of the I2C bit-level master: state registers and next-state logic.
// Depends on i2cbm_pkg.
module i2cbm_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  i2cbm_pkg::t_cmd   i_cmd,
    input  logic [15:0]       i_ticks,
    output i2cbm_pkg::t_res   o_next
);

    i2cbm_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_bit_index, n_bit_index;
    logic [15:0] r_delay, n_delay;
    logic [7:0]  r_shift, n_shift;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_oe, n_oe;
    logic        r_ack, n_ack;
    logic        r_ack_send, n_ack_send;
    logic [7:0]  r_rx_data, n_rx_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2cbm_pkg::P_IDLE;
            r_bit_index <= '0;
            r_delay     <= '0;
            r_shift     <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_oe        <= 1'b0;
            r_ack       <= 1'b1;
            r_ack_send  <= 1'b0;
            r_rx_data   <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_bit_index <= n_bit_index;
            r_delay     <= n_delay;
            r_shift     <= n_shift;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_oe        <= n_oe;
            r_ack       <= n_ack;
            r_ack_send  <= n_ack_send;
            r_rx_data   <= n_rx_data;
        end
    end

    always_comb begin
        logic              do_enter;
        logic              done;
        i2cbm_pkg::t_phase target;
        logic [15:0]       load;

        do_enter    = 1'b0;
        done        = 1'b0;
        target      = i2cbm_pkg::P_IDLE;
        load        = (i_ticks == 16'd0) ? 16'd1 : i_ticks;
        n_phase     = r_phase;
        n_bit_index = r_bit_index;
        n_delay     = r_delay;
        n_shift     = r_shift;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_oe        = r_oe;
        n_ack       = r_ack;
        n_ack_send  = r_ack_send;
        n_rx_data   = r_rx_data;

        if (r_phase != i2cbm_pkg::P_IDLE) begin
            if (r_delay > 16'd1) begin
                n_delay = r_delay - 16'd1;
            end else begin
                case (r_phase)
                    i2cbm_pkg::P_START_A: begin
                        do_enter = 1'b1;
                        target   = i2cbm_pkg::P_START_B;
                    end
                    i2cbm_pkg::P_START_B: begin
                        do_enter = 1'b1;
                        target   = i2cbm_pkg::P_START_C;
                    end
                    i2cbm_pkg::P_STOP_A: begin
                        do_enter = 1'b1;
                        target   = i2cbm_pkg::P_STOP_B;
                    end
                    i2cbm_pkg::P_STOP_B: begin
                        do_enter = 1'b1;
                        target   = i2cbm_pkg::P_STOP_C;
                    end
                    i2cbm_pkg::P_TX_DATA: begin
                        do_enter = 1'b1;
                        target   = i2cbm_pkg::P_TX_HIGH;
                    end
                    i2cbm_pkg::P_TX_HIGH: begin
                        do_enter = 1'b1;
                        target   = i2cbm_pkg::P_TX_LOW;
                    end
                    i2cbm_pkg::P_TX_LOW: begin
                        n_bit_index = r_bit_index + 4'd1;
                        do_enter    = 1'b1;
                        target      = (n_bit_index >= 4'(i2cbm_pkg::BITS_PER_BYTE))
                                      ? i2cbm_pkg::P_TX_ACK : i2cbm_pkg::P_TX_DATA;
                    end
                    i2cbm_pkg::P_TX_ACK: begin
                        n_ack = i_cmd.sda_in;
                        n_scl = 1'b0;
                        n_oe  = 1'b1;
                        done  = 1'b1;
                    end
                    i2cbm_pkg::P_RX_HIGH: begin
                        n_shift  = {r_shift[6:0], i_cmd.sda_in};
                        do_enter = 1'b1;
                        target   = i2cbm_pkg::P_RX_LOW;
                    end
                    i2cbm_pkg::P_RX_LOW: begin
                        n_bit_index = r_bit_index + 4'd1;
                        do_enter    = 1'b1;
                        target      = (n_bit_index >= 4'(i2cbm_pkg::BITS_PER_BYTE))
                                      ? i2cbm_pkg::P_RX_ACKD : i2cbm_pkg::P_RX_HIGH;
                    end
                    i2cbm_pkg::P_RX_ACKD: begin
                        do_enter = 1'b1;
                        target   = i2cbm_pkg::P_RX_ACKH;
                    end
                    i2cbm_pkg::P_RX_ACKH: begin
                        n_scl     = 1'b0;
                        n_rx_data = r_shift;
                        done      = 1'b1;
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
        end else if (i_cmd.cmd_valid && (i_cmd.func <= i2cbm_pkg::FUNC_RELEASE)) begin
            n_bit_index = '0;
            case (i_cmd.func)
                i2cbm_pkg::FUNC_START: begin
                    do_enter = 1'b1;
                    target   = i2cbm_pkg::P_START_A;
                end
                i2cbm_pkg::FUNC_STOP: begin
                    do_enter = 1'b1;
                    target   = i2cbm_pkg::P_STOP_A;
                end
                i2cbm_pkg::FUNC_WRITE: begin
                    n_shift  = i_cmd.tx_byte;
                    do_enter = 1'b1;
                    target   = i2cbm_pkg::P_TX_DATA;
                end
                i2cbm_pkg::FUNC_READ: begin
                    n_shift    = '0;
                    n_ack_send = i_cmd.nack_to_send;
                    do_enter   = 1'b1;
                    target     = i2cbm_pkg::P_RX_HIGH;
                end
                default: begin
                    n_scl = 1'b1;
                    n_sda = 1'b1;
                    done  = 1'b1;
                end
            endcase
        end

        if (done && (r_phase != i2cbm_pkg::P_IDLE)) begin
            n_phase = i2cbm_pkg::P_IDLE;
            n_delay = '0;
        end

        if (do_enter) begin
            n_phase = target;
            n_delay = load;
            case (target)
                i2cbm_pkg::P_START_A: begin
                    n_scl = 1'b1;
                    n_sda = 1'b1;
                    n_oe  = 1'b1;
                end
                i2cbm_pkg::P_START_B: n_sda = 1'b0;
                i2cbm_pkg::P_START_C: n_scl = 1'b0;
                i2cbm_pkg::P_STOP_A: begin
                    n_scl = 1'b0;
                    n_sda = 1'b0;
                    n_oe  = 1'b1;
                end
                i2cbm_pkg::P_STOP_B:  n_scl = 1'b1;
                i2cbm_pkg::P_STOP_C:  n_sda = 1'b1;
                i2cbm_pkg::P_TX_DATA: begin
                    n_oe  = 1'b1;
                    n_sda = n_shift[3'd7 - n_bit_index[2:0]];
                end
                i2cbm_pkg::P_TX_HIGH: n_scl = 1'b1;
                i2cbm_pkg::P_TX_LOW:  n_scl = 1'b0;
                i2cbm_pkg::P_TX_ACK: begin
                    n_oe  = 1'b0;
                    n_scl = 1'b1;
                end
                i2cbm_pkg::P_RX_HIGH: begin
                    n_oe  = 1'b0;
                    n_scl = 1'b1;
                end
                i2cbm_pkg::P_RX_LOW:  n_scl = 1'b0;
                i2cbm_pkg::P_RX_ACKD: begin
                    n_oe  = 1'b1;
                    n_sda = n_ack_send;
                end
                i2cbm_pkg::P_RX_ACKH: n_scl = 1'b1;
                default: begin
                end
            endcase
        end

        o_next.scl_level = n_scl;
        o_next.sda_level = n_sda;
        o_next.sda_drive = n_oe;
        o_next.busy_res  = (n_phase != i2cbm_pkg::P_IDLE);
        o_next.done_res  = done;
        o_next.rx_byte   = n_rx_data;
        o_next.ack_seen  = n_ack;
    end

endmodule

// ===== hw/rtl/i2c_bit_level_master.sv =====
// Top level of the I2C bit-level master: delay register, result register, handshake.
// Depends on i2cbm_pkg, i2cbm_cmd_if, i2cbm_res_if, i2cbm_engine and assert_macros.svh.
// Each transfer on i_cmd is one bus tick and yields exactly one transfer on o_res,
// which shows the line levels, busy, done, the received byte and the acknowledge as
// they stand after that tick. A tick is taken in every cycle unless o_res stalls: the
// engine state and the result register update together, so the result appears in the
// cycle after acceptance, and i_cmd.ready stays high while the result register is empty
// or being drained. Write the delay register only while no command is in progress.
`include "assert_macros.svh"

module i2c_bit_level_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    i2cbm_cmd_if.sink   i_cmd,
    i2cbm_res_if.source o_res
);

    logic            r_out_valid;
    logic [15:0]     r_ticks;
    i2cbm_pkg::t_res r_res;
    i2cbm_pkg::t_res eng_next;
    i2cbm_pkg::t_cmd cmd;
    logic            take;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign take        = i_cmd.valid && i_cmd.ready;

    assign cmd.cmd_valid    = i_cmd.cmd_valid;
    assign cmd.func         = i_cmd.func;
    assign cmd.tx_byte      = i_cmd.tx_byte;
    assign cmd.nack_to_send = i_cmd.nack_to_send;
    assign cmd.sda_in       = i_cmd.sda_in;

    i2cbm_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (take),
        .i_cmd   (cmd),
        .i_ticks (r_ticks),
        .o_next  (eng_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= i2cbm_pkg::TICKS_RESET;
        end else if (i_cfg_we) begin
            r_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= eng_next;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.scl_level = r_res.scl_level;
    assign o_res.sda_level = r_res.sda_level;
    assign o_res.sda_drive = r_res.sda_drive;
    assign o_res.busy_res  = r_res.busy_res;
    assign o_res.done_res  = r_res.done_res;
    assign o_res.rx_byte   = r_res.rx_byte;
    assign o_res.ack_seen  = r_res.ack_seen;

    `ASSERT_CLK(a_take_gives_result, i_clk, i_rst_n, take |=> r_out_valid, "accepted tick gave no result")
    `ASSERT_CLK(a_stall_blocks_input, i_clk, i_rst_n, (r_out_valid && !o_res.ready) |-> !i_cmd.ready, "tick accepted while result stalled")
    `ASSERT_CLK(a_done_not_busy, i_clk, i_rst_n, (r_out_valid && r_res.done_res) |-> !r_res.busy_res, "done reported while still busy")

endmodule

// ===== tb/sv/i2cbm_checker.sv =====
`timescale 1ns / 100ps
// Checker for the I2C bit-level master: predicts the line and status result of every
// accepted bus tick and compares it with each transfer on the result channel.
// Depends on i2cbm_pkg, i2cbm_cmd_if and i2cbm_res_if.
module i2cbm_checker
    import i2cbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    i2cbm_cmd_if        i_cmd,
    i2cbm_res_if        i_res,
    output int          o_errors,
    output int          o_pending,
    output logic        o_busy
);

    logic [15:0] delay_ticks;
    t_phase      seg;
    logic [3:0]  bit_cnt;
    logic [15:0] seg_left;
    logic [7:0]  shifter;
    logic [7:0]  rx_hold;
    logic        scl_q;
    logic        sda_q;
    logic        sda_oe_q;
    logic        ack_q;
    logic        ack_out;
    logic        done_q;
    t_res        line_results[$];
    int          mismatches = 0;

    function automatic void enter_segment(input t_phase p);
        seg = p;
        seg_left = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;
        case (p)
            P_START_A: begin
                scl_q = 1'b1;
                sda_q = 1'b1;
                sda_oe_q = 1'b1;
            end
            P_START_B: sda_q = 1'b0;
            P_START_C: scl_q = 1'b0;
            P_STOP_A: begin
                scl_q = 1'b0;
                sda_q = 1'b0;
                sda_oe_q = 1'b1;
            end
            P_STOP_B: scl_q = 1'b1;
            P_STOP_C: sda_q = 1'b1;
            P_TX_DATA: begin
                sda_oe_q = 1'b1;
                sda_q = shifter[3'd7 - bit_cnt[2:0]];
            end
            P_TX_HIGH: scl_q = 1'b1;
            P_TX_LOW: scl_q = 1'b0;
            P_TX_ACK, P_RX_HIGH: begin
                sda_oe_q = 1'b0;
                scl_q = 1'b1;
            end
            P_RX_LOW: scl_q = 1'b0;
            P_RX_ACKD: begin
                sda_oe_q = 1'b1;
                sda_q = ack_out;
            end
            P_RX_ACKH: scl_q = 1'b1;
            default: ;
        endcase
    endfunction

    function automatic void end_command();
        seg = P_IDLE;
        seg_left = 16'd0;
        done_q = 1'b1;
    endfunction

    function automatic void end_segment(input logic sda_in);
        case (seg)
            P_START_A: enter_segment(P_START_B);
            P_START_B: enter_segment(P_START_C);
            P_STOP_A: enter_segment(P_STOP_B);
            P_STOP_B: enter_segment(P_STOP_C);
            P_TX_DATA: enter_segment(P_TX_HIGH);
            P_TX_HIGH: enter_segment(P_TX_LOW);
            P_TX_LOW: begin
                bit_cnt = bit_cnt + 4'd1;
                enter_segment(bit_cnt >= BITS_PER_BYTE ? P_TX_ACK : P_TX_DATA);
            end
            P_TX_ACK: begin
                ack_q = sda_in;
                scl_q = 1'b0;
                sda_oe_q = 1'b1;
                end_command();
            end
            P_RX_HIGH: begin
                shifter = {shifter[6:0], sda_in};
                enter_segment(P_RX_LOW);
            end
            P_RX_LOW: begin
                bit_cnt = bit_cnt + 4'd1;
                enter_segment(bit_cnt >= BITS_PER_BYTE ? P_RX_ACKD : P_RX_HIGH);
            end
            P_RX_ACKD: enter_segment(P_RX_ACKH);
            P_RX_ACKH: begin
                scl_q = 1'b0;
                rx_hold = shifter;
                end_command();
            end
            default: end_command();
        endcase
    endfunction

    function automatic t_res bus_tick(input t_cmd c);
        t_res r;
        done_q = 1'b0;
        if (seg != P_IDLE) begin
            if (seg_left > 16'd1) begin
                seg_left = seg_left - 16'd1;
            end else begin
                end_segment(c.sda_in);
            end
        end else if (c.cmd_valid && c.func <= FUNC_RELEASE) begin
            bit_cnt = 4'd0;
            case (c.func)
                FUNC_START: enter_segment(P_START_A);
                FUNC_STOP: enter_segment(P_STOP_A);
                FUNC_WRITE: begin
                    shifter = c.tx_byte;
                    enter_segment(P_TX_DATA);
                end
                FUNC_READ: begin
                    shifter = 8'd0;
                    ack_out = c.nack_to_send;
                    enter_segment(P_RX_HIGH);
                end
                default: begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                    done_q = 1'b1;
                end
            endcase
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.sda_drive = sda_oe_q;
        r.busy_res = (seg != P_IDLE);
        r.done_res = done_q;
        r.rx_byte = rx_hold;
        r.ack_seen = ack_q;
        return r;
    endfunction

    function automatic string fmt_res(input t_res r);
        return $sformatf("scl=%b sda=%b drive=%b busy=%b done=%b rx=%h ack=%b",
                         r.scl_level, r.sda_level, r.sda_drive, r.busy_res,
                         r.done_res, r.rx_byte, r.ack_seen);
    endfunction

    always @(posedge i_clk) begin : watch
        t_cmd cmd_item;
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            delay_ticks = TICKS_RESET;
            seg = P_IDLE;
            bit_cnt = 4'd0;
            seg_left = 16'd0;
            shifter = 8'd0;
            rx_hold = 8'd0;
            scl_q = 1'b1;
            sda_q = 1'b1;
            sda_oe_q = 1'b0;
            ack_q = 1'b1;
            ack_out = 1'b0;
            done_q = 1'b0;
            line_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got = {i_res.scl_level, i_res.sda_level, i_res.sda_drive, i_res.busy_res,
                       i_res.done_res, i_res.rx_byte, i_res.ack_seen};
                if (line_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result with no tick pending: %s", $time, fmt_res(got));
                    end
                end else begin
                    want = line_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch, expected %s, got %s",
                                     $time, fmt_res(want), fmt_res(got));
                        end
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                cmd_item = {i_cmd.cmd_valid, i_cmd.func, i_cmd.tx_byte, i_cmd.nack_to_send,
                            i_cmd.sda_in};
                line_results.push_back(bus_tick(cmd_item));
            end
            if (i_cfg_we) begin
                delay_ticks = i_cfg_wdata;
            end
        end
        o_errors <= mismatches;
        o_pending <= line_results.size();
        o_busy <= (seg != P_IDLE);
    end

endmodule

// ===== tb/sv/tb_i2c_bit_level_master.sv =====
`timescale 1ns / 100ps
// Top of the I2C bit-level master testbench: clock, reset, bus tick stimulus under
// several idling modes, delay register writes and the verdict.
// Depends on i2cbm_pkg, i2cbm_cmd_if, i2cbm_res_if, i2cbm_checker and the block.
module tb_i2c_bit_level_master;
    import i2cbm_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_TICKS = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          errors;
    int          pending;
    logic        model_busy;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_asks = 0;
    int          hold_served = 0;
    int          ticks_sent = 0;
    int          cmds_sent = 0;

    i2cbm_cmd_if cmd_ch();
    i2cbm_res_if res_ch();

    i2c_bit_level_master DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch)
    );

    i2cbm_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_cmd      (cmd_ch),
        .i_res      (res_ch),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_busy     (model_busy)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // The result side stalls at random; on request it holds off for a long stretch.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != hold_served) begin
                hold_served = hold_asks;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic put_tick(input logic cv, input logic [2:0] f, input logic [7:0] b,
                            input logic nk);
        while ($urandom_range(99) < idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd_valid <= cv;
        cmd_ch.func <= f;
        cmd_ch.tx_byte <= b;
        cmd_ch.nack_to_send <= nk;
        cmd_ch.sda_in <= 1'($urandom_range(1));
        do @(posedge i_clk); while (!cmd_ch.ready);
        ticks_sent++;
    endtask

    // Busy lags by one transfer, so one filler always goes out before it is trusted.
    task automatic drain(input logic noisy);
        do begin
            if (noisy) begin
                put_tick($urandom_range(9) == 0, 3'($urandom_range(7)),
                         8'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                put_tick(1'b0, 3'($urandom_range(7)), 8'($urandom_range(255)),
                         1'($urandom_range(1)));
            end
        end while (model_busy);
    endtask

    task automatic run_cmd(input logic [2:0] f, input logic [7:0] b, input logic nk,
                           input logic noisy);
        put_tick(1'b1, f, b, nk);
        cmds_sent++;
        drain(noisy);
    endtask

    task automatic settle();
        drain(1'b0);
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_delay(input logic [15:0] v);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_mode(input int idle, input int stall);
        idle_pct = idle;
        stall_pct <= stall;
    endtask

    task automatic random_phase(input int n_ticks);
        int stop_at;
        int n;
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at) begin
            if ($urandom_range(99) < 80) begin
                run_cmd(FUNC_START, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
                n = $urandom_range(1, 3);
                repeat (n) begin
                    run_cmd($urandom_range(1) ? FUNC_WRITE : FUNC_READ,
                            8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
                end
                run_cmd(FUNC_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
                if ($urandom_range(3) == 0) begin
                    run_cmd(FUNC_RELEASE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                            1'b1);
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    put_tick(1'($urandom_range(1)), 3'($urandom_range(7)),
                             8'($urandom_range(255)), 1'($urandom_range(1)));
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 16'd0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd_valid = 1'b0;
        cmd_ch.func = FUNC_START;
        cmd_ch.tx_byte = 8'd0;
        cmd_ch.nack_to_send = 1'b0;
        cmd_ch.sda_in = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first commands run at the delay the register holds after reset.
        set_mode(0, 0);
        run_cmd(FUNC_RELEASE, 8'h00, 1'b0, 1'b0);
        run_cmd(FUNC_START, 8'h00, 1'b0, 1'b0);
        run_cmd(FUNC_WRITE, 8'h00, 1'b0, 1'b0);
        write_delay(16'd2);
        run_cmd(FUNC_WRITE, 8'hFF, 1'b1, 1'b0);
        // Commands offered while busy and on the done tick are ignored.
        run_cmd(FUNC_WRITE, 8'hA5, 1'b0, 1'b1);
        drain(1'b0);
        run_cmd(FUNC_READ, 8'h5A, 1'b0, 1'b0);
        run_cmd(FUNC_READ, 8'hFF, 1'b1, 1'b0);
        run_cmd(FUNC_STOP, 8'h00, 1'b0, 1'b0);
        for (int f = FUNC_RELEASE + 1; f < 2 ** $bits(cmd_ch.func); f++) begin
            run_cmd(3'(f), 8'h00, 1'b0, 1'b0);
        end
        run_cmd(FUNC_RELEASE, 8'hFF, 1'b1, 1'b0);

        // A zero delay behaves as a delay of one tick.
        write_delay(16'd0);
        run_cmd(FUNC_START, 8'h00, 1'b0, 1'b0);
        run_cmd(FUNC_WRITE, 8'($urandom_range(255)), 1'b0, 1'b0);
        run_cmd(FUNC_READ, 8'h00, 1'($urandom_range(1)), 1'b0);
        run_cmd(FUNC_STOP, 8'h00, 1'b0, 1'b0);

        write_delay(16'hFFFF);
        run_cmd(FUNC_RELEASE, 8'h00, 1'b0, 1'b0);

        write_delay(16'd1);
        set_mode(0, 0);
        hold_asks <= hold_asks + 1;
        random_phase(RANDOM_TICKS);

        write_delay(16'd2);
        set_mode(68, 0);
        random_phase(RANDOM_TICKS);

        write_delay(16'd3);
        set_mode(0, 68);
        random_phase(RANDOM_TICKS);

        write_delay(16'd1);
        set_mode(37, 37);
        random_phase(RANDOM_TICKS);

        settle();
        repeat (4) @(posedge i_clk);
        $display("Covered %0d bus ticks and %0d commands with the delay set to 0, 1, 2, 3,",
                 ticks_sent, cmds_sent);
        $display("5 and 65535, tick and result idling up to 68 percent and one long hold-off.");
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
